// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sweep generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSPG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RSPG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RSPG_ASSERT(label, clk, rst_n, prop)
`define RSPG_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- sv/rspg_pkg.sv -----
// ----------------------------------------------------------------------------
// Sweep generator package
// Types, constants and the CORDIC angle table shared by the sweep generator.
// ----------------------------------------------------------------------------
package rspg_pkg;

  localparam int AngFrac = 24;
  localparam int AngW = 36;
  localparam int CoordW = 40;
  localparam int StepW = 6;
  localparam int GainShift = 30;
  localparam logic signed [31:0] InvGain = 32'sd652032874;
  localparam logic signed [AngW-1:0] Deg90 = 36'sd1509949440;
  localparam logic signed [AngW-1:0] Deg180 = 36'sd3019898880;
  localparam logic signed [AngW-1:0] Deg360 = 36'sd6039797760;

  typedef enum logic [1:0] {
    RegStepCount = 2'd0,
    RegSweepAngle = 2'd1,
    RegRadiusChange = 2'd2,
    RegZShift = 2'd3
  } reg_idx_e;

  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] k);
    logic signed [AngW-1:0] v;
    case (k)
      5'd0: v = 36'sd754974720;  5'd1: v = 36'sd445687602;
      5'd2: v = 36'sd235489088;  5'd3: v = 36'sd119537938;
      5'd4: v = 36'sd60000934;   5'd5: v = 36'sd30029717;
      5'd6: v = 36'sd15018523;   5'd7: v = 36'sd7509720;
      5'd8: v = 36'sd3754917;    5'd9: v = 36'sd1877466;
      5'd10: v = 36'sd938734;    5'd11: v = 36'sd469367;
      5'd12: v = 36'sd234684;    5'd13: v = 36'sd117342;
      5'd14: v = 36'sd58671;     5'd15: v = 36'sd29335;
      5'd16: v = 36'sd14668;     5'd17: v = 36'sd7334;
      5'd18: v = 36'sd3667;      5'd19: v = 36'sd1833;
      5'd20: v = 36'sd917;       5'd21: v = 36'sd458;
      5'd22: v = 36'sd229;       5'd23: v = 36'sd115;
      5'd24: v = 36'sd57;        5'd25: v = 36'sd29;
      5'd26: v = 36'sd14;        5'd27: v = 36'sd7;
      5'd28: v = 36'sd4;         5'd29: v = 36'sd2;
      5'd30: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // One CORDIC micro-rotation state.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_t;

endpackage

// ----- sv/rspg_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input points and swept output points.
// ----------------------------------------------------------------------------
interface rspg_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  modport source (output valid, px, py, pz, input ready);
  modport sink (input valid, px, py, pz, output ready);
endinterface

interface rspg_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] qx;
  logic signed [31:0] qy;
  logic signed [31:0] qz;
  logic [5:0] level;
  logic last;
  modport source (output valid, qx, qy, qz, level, last, input ready);
  modport sink (input valid, qx, qy, qz, level, last, output ready);
endinterface

// ----- sv/rotational_sweep_point_generator.sv -----
// ----------------------------------------------------------------------------
// Rotational sweep point generator
// Emits a base point and step_count rotated, scaled and lifted copies.
// ----------------------------------------------------------------------------
// Channel   Dir  Words
// in_if     in   one point (px, py, pz)
// out_if    out  step_count + 1 points (qx, qy, qz, level, last)
// cfg       in   register writes, index 0..3
//
// One output word leaves per cycle unless out_if stalls; the sequencer that
// expands a point issues its step_count + 1 words. Behind it a deep pipeline
// (vectoring CORDIC, bit-per-stage dividers, rotation CORDIC) of 104 register
// stages runs. Reset clears valid bits and the level counter and loads the
// configuration defaults. The whole pipeline advances only when its last stage
// is free, so a stall freezes every stage and nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotational_sweep_point_generator #(
  parameter int CORDIC_ITERATIONS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rspg_in_if.sink     in_if,
  rspg_out_if.source  out_if
);

  localparam int CW = rspg_pkg::CoordW;
  localparam int AW = rspg_pkg::AngW;
  localparam int NI = CORDIC_ITERATIONS;
  localparam int DW = 48;

  logic [5:0]         steps_q;
  logic signed [25:0] sweep_q;
  logic signed [31:0] dr_q;
  logic signed [31:0] dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= 6'd12;
      sweep_q <= 26'sd23592960;
      dr_q <= '0;
      dz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rspg_pkg::reg_idx_e'(cfg_idx_i))
        rspg_pkg::RegStepCount: steps_q <= cfg_data_i[5:0];
        rspg_pkg::RegSweepAngle: sweep_q <= cfg_data_i[25:0];
        rspg_pkg::RegRadiusChange: dr_q <= cfg_data_i;
        rspg_pkg::RegZShift: dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;

  // Sequencer: holds one point and walks its level counter.
  logic               sq_busy_q;
  logic [5:0]         sq_i_q;
  logic signed [31:0] sq_x_q, sq_y_q, sq_z_q;
  logic               last_now;
  logic               issue;

  assign last_now = (sq_i_q == steps_q);
  assign issue = sq_busy_q && en;
  assign in_if.ready = !sq_busy_q || (en && last_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_i_q <= '0;
    end else if (in_if.valid && in_if.ready) begin
      sq_busy_q <= 1'b1;
      sq_i_q <= '0;
    end else if (issue) begin
      if (last_now) sq_busy_q <= 1'b0;
      else sq_i_q <= sq_i_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sq_x_q <= in_if.px;
      sq_y_q <= in_if.py;
      sq_z_q <= in_if.pz;
    end
  end

  // Per-word payload carried alongside the pipeline.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [5:0]         lvl;
    logic               lst;
  } tag_t;

  tag_t tag_in;
  assign tag_in = '{x: sq_x_q, y: sq_y_q, z: sq_z_q, lvl: sq_i_q, lst: last_now};

  // Numerators i*total, one 32x6 multiply per word, registered.
  logic               m_vld_q;
  tag_t               m_tag_q;
  logic signed [DW-1:0] m_ang_q, m_dr_q, m_dz_q;
  logic [5:0]         m_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= issue;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_tag_q <= tag_in;
      m_n_q <= steps_q;
      m_ang_q <= DW'($signed({1'b0, sq_i_q})) *
                 (DW'(sweep_q) <<< (rspg_pkg::AngFrac - FRAC_BITS));
      m_dr_q <= DW'($signed({1'b0, sq_i_q})) * DW'(dr_q);
      m_dz_q <= DW'($signed({1'b0, sq_i_q})) * DW'(dz_q);
    end
  end

  logic d_vld;
  tag_t d_tag;
  logic signed [DW-1:0] q_ang, q_dr, q_dz;
  logic [5:0] nz;
  assign nz = (m_n_q == 6'd0) ? 6'd1 : m_n_q;

  rspg_divider #(.NumW(DW), .TagW($bits(tag_t))) u_div_ang (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m_vld_q), .num_i(m_ang_q), .den_i(nz),
    .tag_i(m_tag_q), .valid_o(d_vld), .quo_o(q_ang), .tag_o(d_tag));
  logic unused_v1, unused_v2;
  logic [$bits(tag_t)-1:0] unused_t1, unused_t2;
  rspg_divider #(.NumW(DW), .TagW($bits(tag_t))) u_div_dr (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m_vld_q), .num_i(m_dr_q), .den_i(nz),
    .tag_i(m_tag_q), .valid_o(unused_v1), .quo_o(q_dr), .tag_o(unused_t1));
  rspg_divider #(.NumW(DW), .TagW($bits(tag_t))) u_div_dz (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m_vld_q), .num_i(m_dz_q), .den_i(nz),
    .tag_i(m_tag_q), .valid_o(unused_v2), .quo_o(q_dz), .tag_o(unused_t2));

  // Vectoring CORDIC, one iteration per stage, pre-rotation in stage 0.
  logic [NI:0]        v_vld_q;
  rspg_pkg::cordic_t  v_q [NI+1];
  tag_t               v_tag_q [NI+1];
  logic signed [AW-1:0] v_ang_q [NI+1];
  logic signed [DW-1:0] v_dr_q [NI+1], v_dz_q [NI+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_vld_q <= '0;
    else if (en) v_vld_q <= {v_vld_q[NI-1:0], d_vld};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (d_tag.x < 0) begin
        v_q[0].x <= -CW'(d_tag.x);
        v_q[0].y <= -CW'(d_tag.y);
        v_q[0].z <= rspg_pkg::Deg180;
      end else begin
        v_q[0].x <= CW'(d_tag.x);
        v_q[0].y <= CW'(d_tag.y);
        v_q[0].z <= '0;
      end
      v_tag_q[0] <= d_tag;
      v_ang_q[0] <= AW'(q_ang);
      v_dr_q[0] <= q_dr;
      v_dz_q[0] <= q_dz;
      for (int k = 0; k < NI; k++) begin
        if (v_q[k].y >= 0) begin
          v_q[k+1].x <= v_q[k].x + (v_q[k].y >>> k);
          v_q[k+1].y <= v_q[k].y - (v_q[k].x >>> k);
          v_q[k+1].z <= v_q[k].z + rspg_pkg::atan_q24(5'(k));
        end else begin
          v_q[k+1].x <= v_q[k].x - (v_q[k].y >>> k);
          v_q[k+1].y <= v_q[k].y + (v_q[k].x >>> k);
          v_q[k+1].z <= v_q[k].z - rspg_pkg::atan_q24(5'(k));
        end
        v_tag_q[k+1] <= v_tag_q[k];
        v_ang_q[k+1] <= v_ang_q[k];
        v_dr_q[k+1] <= v_dr_q[k];
        v_dz_q[k+1] <= v_dz_q[k];
      end
    end
  end

  // Ungain radius and form target angle.
  logic g_vld_q;
  tag_t g_tag_q;
  logic signed [63:0] g_prod_q;
  logic signed [AW-1:0] g_phi_q;
  logic signed [DW-1:0] g_dr_q, g_dz_q;
  logic g_axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= v_vld_q[NI];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_tag_q <= v_tag_q[NI];
      g_prod_q <= 64'(v_q[NI].x[33:0]) * 64'(rspg_pkg::InvGain) + (64'sd1 <<< 29);
      g_phi_q <= v_q[NI].z + v_ang_q[NI];
      g_dr_q <= v_dr_q[NI];
      g_dz_q <= v_dz_q[NI];
      g_axis_q <= (v_tag_q[NI].x == 0) && (v_tag_q[NI].y == 0);
    end
  end

  // Reduce angle, fold, form radius.
  logic h_vld_q;
  tag_t h_tag_q;
  logic signed [DW-1:0] h_r_q, h_dz_q;
  logic signed [AW-1:0] h_phi_q;
  logic h_axis_q;
  logic signed [AW+1:0] phi_w;
  logic signed [DW-1:0] r_w;

  always_comb begin
    r_w = DW'(g_prod_q >>> rspg_pkg::GainShift) + g_dr_q;
    phi_w = (AW+2)'(g_phi_q);
    // Base angle lies within about -100..280 deg and the swept angle within
    // +-512 deg, so two wraps in each direction always suffice.
    if (phi_w > (AW+2)'(rspg_pkg::Deg180)) phi_w = phi_w - (AW+2)'(rspg_pkg::Deg360);
    if (phi_w > (AW+2)'(rspg_pkg::Deg180)) phi_w = phi_w - (AW+2)'(rspg_pkg::Deg360);
    if (phi_w <= -(AW+2)'(rspg_pkg::Deg180)) phi_w = phi_w + (AW+2)'(rspg_pkg::Deg360);
    if (phi_w <= -(AW+2)'(rspg_pkg::Deg180)) phi_w = phi_w + (AW+2)'(rspg_pkg::Deg360);
    if (phi_w > (AW+2)'(rspg_pkg::Deg90)) begin
      phi_w = phi_w - (AW+2)'(rspg_pkg::Deg180);
      r_w = -r_w;
    end else if (phi_w < -(AW+2)'(rspg_pkg::Deg90)) begin
      phi_w = phi_w + (AW+2)'(rspg_pkg::Deg180);
      r_w = -r_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else if (en) h_vld_q <= g_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_tag_q <= g_tag_q;
      h_r_q <= r_w;
      h_phi_q <= AW'(phi_w);
      h_dz_q <= g_dz_q;
      h_axis_q <= g_axis_q;
    end
  end

  // Ungain the new radius, which may be negative.
  logic u_vld_q;
  tag_t u_tag_q;
  logic signed [79:0] u_prod_q;
  logic signed [AW-1:0] u_phi_q;
  logic signed [DW-1:0] u_dz_q;
  logic u_axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) u_vld_q <= 1'b0;
    else if (en) u_vld_q <= h_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_tag_q <= h_tag_q;
      u_prod_q <= 80'($signed(h_r_q[35:0])) * 80'(rspg_pkg::InvGain) + (80'sd1 <<< 29);
      u_phi_q <= h_phi_q;
      u_dz_q <= h_dz_q;
      u_axis_q <= h_axis_q;
    end
  end

  // Rotation CORDIC.
  logic [NI:0]        r_vld_q;
  rspg_pkg::cordic_t  r_q [NI+1];
  tag_t               r_tag_q [NI+1];
  logic signed [DW-1:0] r_dz_q [NI+1];
  logic               r_axis_q [NI+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r_vld_q <= '0;
    else if (en) r_vld_q <= {r_vld_q[NI-1:0], u_vld_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0].x <= CW'(u_prod_q >>> rspg_pkg::GainShift);
      r_q[0].y <= '0;
      r_q[0].z <= u_phi_q;
      r_tag_q[0] <= u_tag_q;
      r_dz_q[0] <= u_dz_q;
      r_axis_q[0] <= u_axis_q;
      for (int k = 0; k < NI; k++) begin
        if (r_q[k].z >= 0) begin
          r_q[k+1].x <= r_q[k].x - (r_q[k].y >>> k);
          r_q[k+1].y <= r_q[k].y + (r_q[k].x >>> k);
          r_q[k+1].z <= r_q[k].z - rspg_pkg::atan_q24(5'(k));
        end else begin
          r_q[k+1].x <= r_q[k].x + (r_q[k].y >>> k);
          r_q[k+1].y <= r_q[k].y - (r_q[k].x >>> k);
          r_q[k+1].z <= r_q[k].z + rspg_pkg::atan_q24(5'(k));
        end
        r_tag_q[k+1] <= r_tag_q[k];
        r_dz_q[k+1] <= r_dz_q[k];
        r_axis_q[k+1] <= r_axis_q[k];
      end
    end
  end

  // Output register.
  logic               o_vld_q;
  logic signed [31:0] o_x_q, o_y_q, o_z_q;
  logic [5:0]         o_lvl_q;
  logic               o_lst_q;
  tag_t               ft;

  assign ft = r_tag_q[NI];
  assign en = !o_vld_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (en) o_vld_q <= r_vld_q[NI];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_lvl_q <= ft.lvl;
      o_lst_q <= ft.lst;
      if (ft.lvl == 6'd0) begin
        o_x_q <= ft.x;
        o_y_q <= ft.y;
        o_z_q <= ft.z;
      end else begin
        o_x_q <= r_axis_q[NI] ? 32'sd0 : rspg_pkg::sat32(64'(r_q[NI].x));
        o_y_q <= r_axis_q[NI] ? 32'sd0 : rspg_pkg::sat32(64'(r_q[NI].y));
        o_z_q <= rspg_pkg::sat32(64'(ft.z) + 64'(r_dz_q[NI]));
      end
    end
  end

  assign out_if.valid = o_vld_q;
  assign out_if.qx = o_x_q;
  assign out_if.qy = o_y_q;
  assign out_if.qz = o_z_q;
  assign out_if.level = o_lvl_q;
  assign out_if.last = o_lst_q;

  `RSPG_ASSERT_NEXT(a_hold, clk_i, rst_ni, o_vld_q && !out_if.ready, o_vld_q && $stable(o_x_q))
  `RSPG_ASSERT(a_lastlvl, clk_i, rst_ni, !(o_vld_q && o_lst_q && o_lvl_q != steps_q))
  `RSPG_ASSERT(a_accept, clk_i, rst_ni, !(in_if.valid && in_if.ready && sq_busy_q && !last_now))

endmodule

// ----- sv/rspg_divider.sv -----
// ----------------------------------------------------------------------------
// Pipelined divider
// Signed restoring divider, one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module rspg_divider #(
  parameter int NumW = 40,
  parameter int TagW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [5:0]             den_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic signed [NumW-1:0] quo_o,
  output logic [TagW-1:0]        tag_o
);

  logic [NumW:0]   vld_q;
  logic [NumW-1:0] rem_q [NumW+1];
  logic [NumW-1:0] quo_q [NumW+1];
  logic [5:0]      den_q [NumW+1];
  logic            neg_q [NumW+1];
  logic [TagW-1:0] tag_q [NumW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= num_i[NumW-1] ? NumW'(-num_i) : num_i;
      neg_q[0] <= num_i[NumW-1];
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      for (int s = 0; s < NumW; s++) begin
        logic [NumW:0] trial;
        trial = {rem_q[s], quo_q[s][NumW-1]} - {{(NumW-5){1'b0}}, den_q[s]};
        if (!trial[NumW]) begin
          rem_q[s+1] <= trial[NumW-1:0];
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= {rem_q[s][NumW-2:0], quo_q[s][NumW-1]};
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
        end
        neg_q[s+1] <= neg_q[s];
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o = neg_q[NumW] ? NumW'(-quo_q[NumW]) : quo_q[NumW];
  assign tag_o = tag_q[NumW];

endmodule
